[rtl/core/hex_dump_text_decoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// Hex dump text decoder assertion macros
// Concurrent assertion forms used by the decoder parser.
// ----------------------------------------------------------------------------
`ifndef HEX_DUMP_TEXT_DECODER_UNIT_MACROS_SVH
`define HEX_DUMP_TEXT_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HDDU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HDDU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/hddu_pkg.sv]
// ----------------------------------------------------------------------------
// Hex dump text decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hddu_pkg;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_text;
   } item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  byte_value;
      logic [15:0] byte_count;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/hex_dump_text_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Hex dump text decoder unit
// Decodes hex dump text, one character per transfer, into bytes and a status.
// ----------------------------------------------------------------------------
// The req channel carries one text character per transfer in req_tdata; a
// transfer with req_tlast high ends the text and its character is ignored.
// The rsp channel carries at most one result per request: a decoded byte
// when the closing space of a digit pair arrives, or the final status for
// an end-of-text transfer. rsp_tuser gives the result kind (byte, done,
// error) and rsp_tdata holds the byte and the saturating byte count.
// A request is held in the input register, and its result is loaded from
// there into the output register, which drives rsp_tvalid. One request is
// taken every cycle as long as results are drained; the output register
// decouples the channels.
// When the receiver stalls, the held result stays stable and the input
// register still takes one further request; requests that give no result
// keep flowing. Reset empties both registers and returns the parser to the
// start of a line with no error and a zero count. After an end-of-text
// transfer the parser is back in that state for the next text.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_dump_text_decoder_unit #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_char
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] byte_value, [23:8] byte_count
   output logic [1:0]       rsp_tuser    // [1:0] result_kind
);

   logic                 item_valid;
   hddu_pkg::item_type   item;
   logic                 consume;
   logic                 load;
   logic                 out_free;
   hddu_pkg::result_type result;

   hddu_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   hddu_parser #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .consume    (consume),
      .load       (load),
      .result     (result)
   );

   hddu_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[rtl/core/hddu_in_reg.sv]
// ----------------------------------------------------------------------------
// Hex dump text decoder input register
// Holds one accepted character transfer until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hddu_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   input  wire logic              consume,
   output logic                   item_valid,
   output hddu_pkg::item_type     item
);

   logic               valid_ff;
   logic               valid_in;
   hddu_pkg::item_type item_ff;
   logic               accept;

   assign req_tready = !valid_ff || consume;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.text_char   <= req_tdata;
         item_ff.end_of_text <= req_tlast;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[rtl/core/hddu_parser.sv]
// ----------------------------------------------------------------------------
// Hex dump text decoder parser
// Line state, digit pairing, byte counting and final status for one character.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hex_dump_text_decoder_unit_macros.svh"

module hddu_parser #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire hddu_pkg::item_type   item,
   input  wire logic                 out_free,
   output logic                      consume,
   output logic                      load,
   output hddu_pkg::result_type      result
);

   localparam int ShowBits = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CountOne = {{(COUNT_BITS-1){1'b0}}, 1'b1};

   typedef enum logic [2:0] {
      PH_LINE_START  = 3'd0,
      PH_FIRST_DIGIT = 3'd1,
      PH_BOTH_DIGITS = 3'd2,
      PH_TRIPLE_DONE = 3'd3,
      PH_SKIP_REST   = 3'd4
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    lead_ff, lead_in;
   logic                    error_ff, error_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [COUNT_BITS-1:0]   count_inc;
   logic                    produce;
   logic                    is_hex;
   logic [3:0]              nib;
   logic [4:0]              hex_code;
   logic                    bad_end;
   logic [7:0]              c;

   function automatic logic [4:0] hex_decode(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'h10;
      if (ch inside {[8'h30:8'h39]}) begin
         r = {1'b0, 4'(ch - 8'h30)};
      end else if (ch inside {[8'h61:8'h66]}) begin
         r = {1'b0, 4'(ch - 8'h57)};
      end else if (ch inside {[8'h41:8'h46]}) begin
         r = {1'b0, 4'(ch - 8'h37)};
      end
      return r;
   endfunction

   assign c         = item.text_char;
   assign hex_code  = hex_decode(c);
   assign is_hex    = !hex_code[4];
   assign nib       = hex_code[3:0];
   assign count_inc = (count_ff == CountMax) ? count_ff : count_ff + CountOne;

   always_comb begin
      phase_in            = phase_ff;
      byte_in             = byte_ff;
      lead_in             = lead_ff;
      error_in            = error_ff;
      count_in            = count_ff;
      produce             = 1'b0;
      bad_end             = 1'b0;
      result.result_kind  = hddu_pkg::KIND_BYTE;
      result.byte_value   = 8'h00;
      result.byte_count   = 16'(count_ff[ShowBits-1:0]);
      if (item.end_of_text) begin
         bad_end = error_ff || (phase_ff == PH_FIRST_DIGIT) ||
                   (phase_ff == PH_BOTH_DIGITS) || (phase_ff == PH_TRIPLE_DONE) ||
                   ((phase_ff != PH_SKIP_REST) && lead_ff);
         produce            = 1'b1;
         result.result_kind = bad_end ? hddu_pkg::KIND_ERROR : hddu_pkg::KIND_DONE;
         phase_in           = PH_LINE_START;
         byte_in            = 8'h00;
         lead_in            = 1'b0;
         error_in           = 1'b0;
         count_in           = '0;
      end else if (!error_ff) begin
         case (phase_ff)
            PH_FIRST_DIGIT: begin
               if (is_hex) begin
                  byte_in  = {byte_ff[3:0], nib};
                  phase_in = PH_BOTH_DIGITS;
               end else begin
                  error_in = 1'b1;
               end
            end
            PH_BOTH_DIGITS: begin
               if (c == hddu_pkg::CHAR_SPACE) begin
                  produce           = 1'b1;
                  count_in          = count_inc;
                  result.byte_value = byte_ff;
                  result.byte_count = 16'(count_inc[ShowBits-1:0]);
                  byte_in           = 8'h00;
                  phase_in          = PH_TRIPLE_DONE;
               end else begin
                  error_in = 1'b1;
               end
            end
            PH_TRIPLE_DONE: begin
               if (c == hddu_pkg::CHAR_SPACE) begin
                  phase_in = PH_SKIP_REST;
               end else if (c == hddu_pkg::CHAR_NEWLINE) begin
                  phase_in = PH_LINE_START;
                  lead_in  = 1'b0;
               end else if (is_hex) begin
                  byte_in  = {4'h0, nib};
                  phase_in = PH_FIRST_DIGIT;
               end else begin
                  error_in = 1'b1;
               end
            end
            PH_SKIP_REST: begin
               if (c == hddu_pkg::CHAR_NEWLINE) begin
                  phase_in = PH_LINE_START;
                  lead_in  = 1'b0;
               end
            end
            default: begin
               phase_in = PH_LINE_START;
               if (c == hddu_pkg::CHAR_SPACE) begin
                  lead_in = 1'b1;
               end else if (c == hddu_pkg::CHAR_NEWLINE) begin
                  lead_in = 1'b0;
               end else if (is_hex) begin
                  byte_in  = {4'h0, nib};
                  lead_in  = 1'b0;
                  phase_in = PH_FIRST_DIGIT;
               end else begin
                  error_in = 1'b1;
               end
            end
         endcase
      end
   end

   assign consume = item_valid && (!produce || out_free);
   assign load    = consume && produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE_START;
         byte_ff  <= 8'h00;
         lead_ff  <= 1'b0;
         error_ff <= 1'b0;
         count_ff <= '0;
      end else if (consume) begin
         phase_ff <= phase_in;
         byte_ff  <= byte_in;
         lead_ff  <= lead_in;
         error_ff <= error_in;
         count_ff <= count_in;
      end
   end

   `HDDU_ASSERT_IMP(a_silent_after_error, clock, reset, item_valid && error_ff && !item.end_of_text, !produce, "parser produced a result after an error")
   `HDDU_ASSERT_NXT(a_end_restarts, clock, reset, consume && item.end_of_text, (phase_ff == PH_LINE_START) && !error_ff && !lead_ff && (count_ff == '0), "parser did not return to line start after end of text")
   `HDDU_ASSERT_IMP(a_byte_from_pair, clock, reset, load && (result.result_kind == hddu_pkg::KIND_BYTE), phase_ff == PH_BOTH_DIGITS, "byte emitted outside the digit pair phase")
   `HDDU_ASSERT_NXT(a_count_saturates, clock, reset, (count_ff == CountMax) && !(consume && item.end_of_text), count_ff == CountMax, "byte count left its saturated value")

endmodule

`default_nettype wire

[rtl/core/hddu_out_reg.sv]
// ----------------------------------------------------------------------------
// Hex dump text decoder output register
// Holds one result transfer until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hddu_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire hddu_pkg::result_type result,
   output logic                      out_free,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [23:0]               rsp_tdata,
   output logic [1:0]                rsp_tuser
);

   logic                 valid_ff;
   logic                 valid_in;
   hddu_pkg::result_type result_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {result_ff.byte_count, result_ff.byte_value};
   assign rsp_tuser  = result_ff.result_kind;

endmodule

`default_nettype wire

[verif/tb_hex_dump_text_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex dump text decoder unit testbench
// Streams hex dump text into the decoder and checks every decoded byte and
// every end-of-text status against a cycle-free model of the parser. The run
// covers three short directed texts, a short unstalled burst of back-to-back
// triples, and random texts with optional corruption, with random idling on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------

typedef enum logic [2:0] {
   LINE_START,
   FIRST_DIGIT,
   BOTH_DIGITS,
   TRIPLE_DONE,
   SKIP_REST
} parse_phase_type;

class hex_text_scoreboard;
   parse_phase_type      phase;
   logic [7:0]           pair_value;
   bit                   lead_space;
   bit                   faulted;
   logic [15:0]          decoded_count;
   hddu_pkg::result_type expected_q[$];
   int unsigned          failures;
   int unsigned          bytes_seen;
   int unsigned          clean_ends;
   int unsigned          failed_ends;

   function new();
      restart();
      failures = 0;
      bytes_seen = 0;
      clean_ends = 0;
      failed_ends = 0;
   endfunction

   function void restart();
      phase = LINE_START;
      pair_value = 8'h00;
      lead_space = 1'b0;
      faulted = 1'b0;
      decoded_count = 16'h0000;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function logic [4:0] hex_value(logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return 5'(ch - "0");
      if (ch >= "a" && ch <= "f") return 5'(ch - "a" + 8'd10);
      if (ch >= "A" && ch <= "F") return 5'(ch - "A" + 8'd10);
      return 5'd16;
   endfunction

   function void note_request(logic [7:0] ch, logic last);
      hddu_pkg::result_type res;
      logic [4:0]           nib;
      bit                   bad;
      nib = hex_value(ch);
      if (last) begin
         bad = faulted;
         if (phase == FIRST_DIGIT || phase == BOTH_DIGITS || phase == TRIPLE_DONE)
            bad = 1'b1;
         else if (phase != SKIP_REST && lead_space)
            bad = 1'b1;
         res.result_kind = bad ? hddu_pkg::KIND_ERROR : hddu_pkg::KIND_DONE;
         res.byte_value = 8'h00;
         res.byte_count = decoded_count;
         expected_q.push_back(res);
         restart();
         return;
      end
      if (faulted) return;
      case (phase)
         FIRST_DIGIT: begin
            if (!nib[4]) begin
               pair_value = {pair_value[3:0], nib[3:0]};
               phase = BOTH_DIGITS;
            end else begin
               faulted = 1'b1;
            end
         end
         BOTH_DIGITS: begin
            if (ch != hddu_pkg::CHAR_SPACE) begin
               faulted = 1'b1;
            end else begin
               if (decoded_count != 16'hFFFF) decoded_count = decoded_count + 16'd1;
               res.result_kind = hddu_pkg::KIND_BYTE;
               res.byte_value = pair_value;
               res.byte_count = decoded_count;
               expected_q.push_back(res);
               pair_value = 8'h00;
               phase = TRIPLE_DONE;
            end
         end
         TRIPLE_DONE: begin
            if (ch == hddu_pkg::CHAR_SPACE) begin
               phase = SKIP_REST;
            end else if (ch == hddu_pkg::CHAR_NEWLINE) begin
               phase = LINE_START;
               lead_space = 1'b0;
            end else if (!nib[4]) begin
               pair_value = {4'h0, nib[3:0]};
               phase = FIRST_DIGIT;
            end else begin
               faulted = 1'b1;
            end
         end
         SKIP_REST: begin
            if (ch == hddu_pkg::CHAR_NEWLINE) begin
               phase = LINE_START;
               lead_space = 1'b0;
            end
         end
         default: begin
            phase = LINE_START;
            if (ch == hddu_pkg::CHAR_SPACE) begin
               lead_space = 1'b1;
            end else if (ch == hddu_pkg::CHAR_NEWLINE) begin
               lead_space = 1'b0;
            end else if (!nib[4]) begin
               pair_value = {4'h0, nib[3:0]};
               lead_space = 1'b0;
               phase = FIRST_DIGIT;
            end else begin
               faulted = 1'b1;
            end
         end
      endcase
   endfunction

   task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      failures++;
   endtask

   task check_result(logic [1:0] kind, logic [7:0] value, logic [15:0] count);
      hddu_pkg::result_type exp;
      if (expected_q.size() == 0) begin
         report($sformatf("result with nothing expected: kind %0d byte %02h count %0d",
                          kind, value, count));
         return;
      end
      exp = expected_q.pop_front();
      if (kind !== exp.result_kind)
         report($sformatf("result kind %0d, expected %0d", kind, exp.result_kind));
      if (value !== exp.byte_value)
         report($sformatf("byte value %02h, expected %02h", value, exp.byte_value));
      if (count !== exp.byte_count)
         report($sformatf("byte count %0d, expected %0d", count, exp.byte_count));
      case (exp.result_kind)
         hddu_pkg::KIND_BYTE: bytes_seen++;
         hddu_pkg::KIND_DONE: clean_ends++;
         default:             failed_ends++;
      endcase
   endtask
endclass

module tb_hex_dump_text_decoder_unit;

   localparam int TOTAL_ITEMS  = 850;
   localparam int BURST_BYTES  = 16;
   localparam int HOLD_AFTER   = 250;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   hex_text_scoreboard board = new();

   bit          burst_mode = 1'b0;
   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;
   bit          hold_off_pending = 1'b0;
   int unsigned chars_sent = 0;

   hex_dump_text_decoder_unit #(
      .COUNT_BITS(16)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   task automatic send_char(input logic [7:0] ch, input logic last);
      int gap;
      gap = (burst_mode || tx_steady) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      board.note_request(ch, last);
   endtask

   task automatic send_chars(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
      if (nib < 4'd10) return "0" + 8'(nib);
      return (upper ? "A" : "a") + 8'(nib) - 8'd10;
   endfunction

   function automatic logic [7:0] garble(logic [7:0] ch, bit noisy);
      if (noisy && $urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
      return ch;
   endfunction

   task automatic send_triple(input bit noisy);
      send_char(garble(hex_char(4'($urandom), $urandom_range(0, 1)), noisy), 1'b0);
      send_char(garble(hex_char(4'($urandom), $urandom_range(0, 1)), noisy), 1'b0);
      send_char(garble(hddu_pkg::CHAR_SPACE, noisy), 1'b0);
   endtask

   task automatic send_random_text();
      int  lines;
      int  triples;
      int  style;
      int  junk;
      bit  noisy;
      bit  last_line;
      logic [7:0] ch;
      tx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 10)) send_char(8'($urandom_range(0, 255)), 1'b0);
         send_char(8'($urandom_range(0, 255)), 1'b1);
         return;
      end
      noisy = ($urandom_range(0, 4) == 0);
      lines = $urandom_range(1, 5);
      for (int ln = 0; ln < lines; ln++) begin
         last_line = (ln == lines - 1);
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) send_char(hddu_pkg::CHAR_SPACE, 1'b0);
         triples = $urandom_range(0, 8);
         repeat (triples) send_triple(noisy);
         style = last_line ? $urandom_range(0, 5) : $urandom_range(0, 1);
         if (triples == 0 && style != 2) style = 0;
         case (style)
            1, 2: begin
               send_char(hddu_pkg::CHAR_SPACE, 1'b0);
               junk = $urandom_range(0, 6);
               repeat (junk) begin
                  ch = 8'($urandom_range(0, 255));
                  if (ch == hddu_pkg::CHAR_NEWLINE) ch = 8'h00;
                  send_char(ch, 1'b0);
               end
               if (style == 1) send_char(garble(hddu_pkg::CHAR_NEWLINE, noisy), 1'b0);
            end
            3: ;
            4: send_char(hex_char(4'($urandom), $urandom_range(0, 1)), 1'b0);
            5: begin
               send_char(hex_char(4'($urandom), $urandom_range(0, 1)), 1'b0);
               send_char(hex_char(4'($urandom), $urandom_range(0, 1)), 1'b0);
            end
            default: send_char(garble(hddu_pkg::CHAR_NEWLINE, noisy), 1'b0);
         endcase
      end
      send_char(8'($urandom_range(0, 255)), 1'b1);
   endtask

   initial begin : result_side
      int stall;
      int taken;
      taken = 0;
      @(negedge reset);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = (burst_mode || rx_steady) ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_result(rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8]);
         taken++;
         if (taken % 40 == 0) rx_steady = ($urandom_range(0, 9) < 3);
      end
   end

   initial begin : text_side
      bit hold_done;
      hold_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_chars("  00 FF fA  x");
      send_char(8'h00, 1'b0);
      send_chars("\n");
      send_char(8'hFF, 1'b1);
      send_chars("9g1");
      send_char(8'h00, 1'b1);
      send_chars(" ");
      send_char(8'h5A, 1'b1);

      burst_mode = 1'b1;
      repeat (BURST_BYTES) send_triple(1'b0);
      send_char(hddu_pkg::CHAR_NEWLINE, 1'b0);
      send_char(8'h00, 1'b1);
      burst_mode = 1'b0;

      while (chars_sent < TOTAL_ITEMS) begin
         if (!hold_done && chars_sent > HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_off_pending = 1'b1;
         end
         send_random_text();
      end
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending() != 0) board.report("results still expected at the end");
      $display("Run covered %0d characters, including a burst of back-to-back triples.",
               chars_sent);
      $display("Checked %0d decoded bytes, %0d clean and %0d failed text ends.",
               board.bytes_seen, board.clean_ends, board.failed_ends);
      if (board.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #30ms;
      $display("status: fail");
      $finish;
   end

endmodule
